FILE: sv/signed_radix_to_text_defines.svh
// assertion macros shared by the checker
`ifndef SIGNED_RADIX_TO_TEXT_DEFINES_SVH
`define SIGNED_RADIX_TO_TEXT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srtt assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SRTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srtt assertion failed");

`endif

FILE: sv/srtt_pkg.sv
package srtt_pkg;

    typedef logic [3:0]   digit_t;
    typedef logic [7:0]   char_t;
    typedef logic [127:0] alph_t;

    typedef enum logic [1:0] {
        REG_BASE_SIZE  = 2'd0,
        REG_ALPH_LOW   = 2'd1,
        REG_ALPH_HIGH  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_LD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_res_t;

    localparam char_t CTRL_MAX  = 8'd31;
    localparam char_t DEL_CHAR  = 8'd127;
    localparam char_t PLUS_CHAR = 8'h2B;
    localparam char_t MINUS_CHAR = 8'h2D;
    localparam char_t NUL_CHAR  = 8'h00;

    function automatic char_t sym_at(input alph_t alph, input digit_t d);
        return alph[{d, 3'b000} +: 8];
    endfunction

endpackage

FILE: sv/srtt_bchk.sv
module srtt_bchk import srtt_pkg::*; #(
    parameter int MAX_BASE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [4:0] base_size,
    input  alph_t      alph,
    output chk_res_t   res
);

    logic   busy_reg, busy_next;
    logic   done_reg, done_next;
    logic   ok_reg, ok_next;
    digit_t idx_reg, idx_next;

    char_t  cur;
    logic   bad;
    logic   dup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
            idx_reg  <= idx_next;
        end
    end

    // one symbol per cycle, compared against all later symbols in use
    always_comb
    begin
        cur = sym_at(alph, idx_reg);
        bad = (cur <= CTRL_MAX) || (cur >= DEL_CHAR) ||
              (cur == PLUS_CHAR) || (cur == MINUS_CHAR);
        dup = 1'b0;
        for (int j = 0; j < 16; j++)
        begin
            if ((4'(j) > idx_reg) && (5'(j) < base_size) &&
                (sym_at(alph, 4'(j)) == cur))
            begin
                dup = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ok_next   = ok_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            idx_next = '0;
            if ((base_size < 5'd2) || (base_size > 5'(MAX_BASE)))
            begin
                done_next = 1'b1;
                ok_next   = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (bad || dup)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b0;
            end
            else if ({1'b0, idx_reg} == (base_size - 5'd1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ok_next   = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.ok   = ok_reg;

endmodule

FILE: sv/srtt_div.sv
module srtt_div import srtt_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [4:0]            divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output digit_t                remainder
);

    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    digit_t                r_reg, r_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [4:0]            trial;
    logic                  fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {r_reg, q_reg[VALUE_BITS-1]};
        fits      = (trial >= divisor);
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = CW'(VALUE_BITS);
        end
        else if (cnt_reg != '0)
        begin
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            r_next   = fits ? 4'(trial - divisor) : trial[3:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: sv/srtt_stack.sv
module srtt_stack import srtt_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  digit_t                   wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output digit_t                   rdata
);

    digit_t mem [DEPTH];
    digit_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/signed_radix_to_text.sv
// signed_radix_to_text: writes a signed integer as text in a configured radix
//
// the cfg port sets the radix (index 0) and the 16 digit symbols (index 1
// for digits 0..7, index 2 for digits 8..15); write it only while idle
// s_* takes one signed word; m_* returns one character per word, most
// significant digit first, a leading minus for negatives, tlast on the final
// character; an invalid base gives one word with tuser set and tdata zero
// the base check runs first; the shared bit-serial divider then yields
// the digits, least significant first, into the digit store; then the
// sign and each digit character go out in turn, held by any receiver stall
// s_tready is high only while idle; one word is handled at a time
// when the receiver stalls, the character holds in the output register
// and the block waits; reset clears the config, state, value and valid
// registers but not the output character, last and error registers;
// the block comes up idle; the digit store needs no clearing
module signed_radix_to_text import srtt_pkg::*; #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // character
    output logic                              m_tlast,
    output logic                              m_tuser,   // base_error
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [63:0]                       cfg_data
);

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);

    state_t                state_reg, state_next;
    logic [4:0]            base_reg;
    logic [63:0]           alph_lo_reg;
    logic [63:0]           alph_hi_reg;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  ovalid_reg, ovalid_next;
    char_t                 ochar_reg, ochar_next;
    logic                  olast_reg, olast_next;
    logic                  oerr_reg, oerr_next;

    alph_t                 alph;
    logic [VALUE_BITS-1:0] raw;
    logic                  chk_start;
    chk_res_t              chk_res;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_q;
    digit_t                div_r;
    logic                  st_we;
    logic [AW-1:0]         st_raddr;
    digit_t                st_rdata;

    assign alph = {alph_hi_reg, alph_lo_reg};
    assign raw  = s_tdata[VALUE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            alph_lo_reg <= '0;
            alph_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_BASE_SIZE: base_reg    <= cfg_data[4:0];
                REG_ALPH_LOW:  alph_lo_reg <= cfg_data;
                REG_ALPH_HIGH: alph_hi_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            neg_reg    <= neg_next;
            mag_reg    <= mag_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        chk_start   = 1'b0;
        div_start   = 1'b0;
        st_we       = 1'b0;
        st_raddr    = AW'(cnt_reg - 1'b1);
        s_tready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    neg_next   = raw[VALUE_BITS-1];
                    mag_next   = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    cnt_next   = '0;
                    chk_start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_res.done)
                begin
                    if (chk_res.ok)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        ochar_next  = NUL_CHAR;
                        olast_next  = 1'b1;
                        oerr_next   = 1'b1;
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    st_we    = 1'b1;
                    mag_next = div_q;
                    cnt_next = cnt_reg + 1'b1;
                    if ((div_q != '0) && ((cnt_reg + 1'b1) < CW'(VALUE_BITS)))
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_RD;
                    end
                end
            end
            ST_SIGN:
            begin
                ovalid_next = 1'b1;
                ochar_next  = MINUS_CHAR;
                olast_next  = 1'b0;
                oerr_next   = 1'b0;
                state_next  = ST_OUT;
            end
            ST_RD:
            begin
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                ovalid_next = 1'b1;
                ochar_next  = sym_at(alph, st_rdata);
                olast_next  = (cnt_reg == '0);
                oerr_next   = 1'b0;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = (cnt_reg == '0) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    srtt_bchk #(
        .MAX_BASE (MAX_BASE)
    ) u_bchk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (chk_start),
        .base_size (base_reg),
        .alph      (alph),
        .res       (chk_res)
    );

    srtt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_next),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    srtt_stack #(
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (div_r),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = ochar_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = oerr_reg;

endmodule

FILE: sv/srtt_checker.sv
`include "signed_radix_to_text_defines.svh"

module srtt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // an error word is the only word for its input
    `SRTT_ASSERT_NOW(a_err_last, m_tvalid && m_tuser, m_tlast)
    // an error word carries no character
    `SRTT_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == 8'h00)
    // no new input is taken while a character is pending
    `SRTT_ASSERT_NOW(a_one_at_time, m_tvalid, !s_tready)
    // a stalled character holds
    `SRTT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind signed_radix_to_text srtt_checker u_srtt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import srtt_pkg::*;

    localparam int          VALUE_W        = 32;
    localparam int          RADIX_MAX      = 16;
    localparam int          DRAIN_CYCLES   = 50;
    localparam int unsigned TIMEOUT_CYCLES = 4000000;

    localparam alph_t BIN_ALPH = {64'hFFFF_0000_2B2D_0001, 64'h00FF_7F1F_2D2B_3130};
    localparam alph_t HEX_ALPH = {"fedcba98", "76543210"};
    localparam alph_t DEC_ALPH = {64'h0000_0000_0000_7E38, "7654321 "};

    typedef struct packed {
        char_t ch;
        logic  last;
        logic  err;
    } text_word_t;

    class radix_scoreboard;
        logic [4:0]  base_size;
        alph_t       alphabet;
        text_word_t  text_q[$];
        int unsigned fails;

        function new();
            base_size = '0;
            alphabet  = '0;
            fails     = 0;
        endfunction

        function void set_reg(input reg_idx_t idx, input logic [63:0] d);
            case (idx)
                REG_BASE_SIZE: base_size = d[4:0];
                REG_ALPH_LOW:  alphabet[63:0] = d;
                REG_ALPH_HIGH: alphabet[127:64] = d;
                default: ;
            endcase
        endfunction

        function bit radix_valid();
            char_t c;
            if (base_size < 2 || base_size > RADIX_MAX)
                return 1'b0;
            for (int i = 0; i < base_size; i++)
            begin
                c = alphabet[i*8 +: 8];
                if (c <= CTRL_MAX || c >= DEL_CHAR || c == PLUS_CHAR || c == MINUS_CHAR)
                    return 1'b0;
                for (int j = i + 1; j < base_size; j++)
                    if (alphabet[j*8 +: 8] == c)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void push_word(input char_t ch, input logic last, input logic err);
            text_word_t w;
            w.ch   = ch;
            w.last = last;
            w.err  = err;
            text_q.push_back(w);
        endfunction

        function void note_value(input logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            digit_t             digits[$];
            if (!radix_valid())
            begin
                push_word(NUL_CHAR, 1'b1, 1'b1);
                return;
            end
            // unsigned magnitude, so the most negative value converts too
            mag = v[VALUE_W-1] ? -v : v;
            do
            begin
                digits.push_front(4'(mag % base_size));
                mag = mag / base_size;
            end
            while (mag != 0);
            if (v[VALUE_W-1])
                push_word(MINUS_CHAR, 1'b0, 1'b0);
            for (int k = 0; k < digits.size(); k++)
                push_word(alphabet[digits[k]*8 +: 8], k == digits.size() - 1, 1'b0);
        endfunction

        function void check_word(input char_t ch, input logic last, input logic err);
            text_word_t w;
            if (text_q.size() == 0)
            begin
                $error("unexpected word: character %h last %b base_error %b", ch, last, err);
                fails++;
                return;
            end
            w = text_q.pop_front();
            if (ch !== w.ch)
            begin
                $error("character: expected %h, got %h", w.ch, ch);
                fails++;
            end
            if (last !== w.last)
            begin
                $error("last: expected %b, got %b", w.last, last);
                fails++;
            end
            if (err !== w.err)
            begin
                $error("base_error: expected %b, got %b", w.err, err);
                fails++;
            end
        endfunction

        function int pending();
            return text_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;    // value
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;    // character
    logic               m_tlast;
    logic               m_tuser;    // base_error
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    logic               no_idle;
    int unsigned        cycle_count = 0;
    radix_scoreboard    radix_sb;

    signed_radix_to_text u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic offer(input logic [VALUE_W-1:0] v);
        while (!no_idle && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        radix_sb.note_value(v);
        @(negedge clk);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (radix_sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [63:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        radix_sb.set_reg(idx, d);
    endtask

    task automatic load_base(input logic [4:0] size, input alph_t alph);
        logic [63:0] size_word;
        stop_and_drain();
        cfg_write(REG_UNUSED, {$urandom, $urandom});
        // upper bits of the radix word are don't-care
        size_word      = {$urandom, $urandom};
        size_word[4:0] = size;
        cfg_write(REG_BASE_SIZE, size_word);
        cfg_write(REG_ALPH_LOW, alph[63:0]);
        cfg_write(REG_ALPH_HIGH, alph[127:64]);
        cfg_we <= 1'b0;
    endtask

    task automatic try_bad(input logic [4:0] size, input alph_t alph);
        load_base(size, alph);
        offer($urandom);
    endtask

    function automatic alph_t random_alphabet(input int size);
        char_t pool[$];
        char_t t;
        alph_t a;
        int    k;
        for (int c = 32; c < 127; c++)
            if (c != PLUS_CHAR && c != MINUS_CHAR)
                pool.push_back(char_t'(c));
        for (int i = 0; i < RADIX_MAX; i++)
        begin
            k       = $urandom_range(i, pool.size() - 1);
            t       = pool[i];
            pool[i] = pool[k];
            pool[k] = t;
        end
        a = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < size; i++)
            a[i*8 +: 8] = pool[i];
        return a;
    endfunction

    function automatic char_t bad_symbol();
        case ($urandom_range(0, 4))
            0: return char_t'($urandom_range(0, CTRL_MAX));
            1: return DEL_CHAR;
            2: return char_t'($urandom_range(128, 255));
            3: return PLUS_CHAR;
            default: return MINUS_CHAR;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(1, 20);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(VALUE_W-1){1'b0}}};
                    1: return {1'b0, {(VALUE_W-1){1'b1}}};
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned taken;
        int          hold;
        taken    = 0;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                radix_sb.check_word(m_tdata, m_tlast, m_tuser);
                taken++;
                // long receiver stall while the sender keeps offering
                if (taken == 400)
                    hold = 800;
            end
        end
    end

    initial
    begin
        logic [4:0] size;
        alph_t      alph;
        int         kind;
        int         i;
        int         j;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_BASE_SIZE;
        cfg_data  = '0;
        no_idle   = 1'b0;
        radix_sb  = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // radix zero out of reset
        offer(32'd5);

        load_base(5'd2, BIN_ALPH);
        offer(32'd0);
        offer(32'd1);
        offer('1);
        offer({1'b0, {(VALUE_W-1){1'b1}}});
        offer({1'b1, {(VALUE_W-1){1'b0}}});

        load_base(5'd16, HEX_ALPH);
        offer({1'b1, {(VALUE_W-1){1'b0}}});
        offer({1'b0, {(VALUE_W-1){1'b1}}});
        offer('1);
        offer(32'h0123_abcd);

        // space and tilde are the printable extremes
        load_base(5'd10, DEC_ALPH);
        offer(32'd0);
        offer(-32'd1999999999);

        try_bad(5'd1, HEX_ALPH);
        try_bad(5'd17, HEX_ALPH);
        try_bad(5'd31, HEX_ALPH);
        alph = HEX_ALPH;
        alph[3*8 +: 8] = CTRL_MAX;
        try_bad(5'd16, alph);
        alph = HEX_ALPH;
        alph[15*8 +: 8] = DEL_CHAR;
        try_bad(5'd16, alph);
        alph = HEX_ALPH;
        alph[0 +: 8] = 8'h80;
        try_bad(5'd16, alph);
        alph = HEX_ALPH;
        alph[9*8 +: 8] = PLUS_CHAR;
        try_bad(5'd16, alph);
        alph = HEX_ALPH;
        alph[5*8 +: 8] = MINUS_CHAR;
        try_bad(5'd16, alph);
        alph = HEX_ALPH;
        alph[15*8 +: 8] = HEX_ALPH[7:0];
        try_bad(5'd16, alph);

        for (int p = 0; p < 24; p++)
        begin
            kind = $urandom_range(0, 9);
            size = 5'($urandom_range(2, RADIX_MAX));
            alph = random_alphabet(size);
            if (kind == 0)
                size = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                            : 5'($urandom_range(RADIX_MAX + 1, 31));
            else if (kind == 1)
            begin
                i = $urandom_range(0, size - 1);
                alph[i*8 +: 8] = bad_symbol();
            end
            else if (kind == 2)
            begin
                i = $urandom_range(0, size - 2);
                j = $urandom_range(i + 1, size - 1);
                alph[j*8 +: 8] = alph[i*8 +: 8];
            end
            no_idle = (p >= 6 && p < 10);
            load_base(size, alph);
            repeat (16) offer(random_value());
        end

        stop_and_drain();
        if (radix_sb.fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
